// ===== rtl/core/pdr_pkg.sv =====
// Package for the pushdown recognizer: status codes, register indexes,
// table layout constants and sizing defaults. No dependencies.
package pdr_pkg;

  // Sizing defaults
  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_SYMBOLS     = 4;

  // Field and register widths
  localparam int SYM_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int START_W    = 8;
  localparam int ENTRY_W    = 6;
  localparam int TABLE_WORDS = 6;
  localparam int TABLE_W    = TABLE_WORDS * CFG_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TRANS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FINAL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef logic [SYM_W-1:0] sym_t;

endpackage

// ===== rtl/core/pdr_stack.sv =====
// Stack body memory for the pushdown recognizer: holds every entry below
// the top of stack, with a registered read and write-to-read bypass.
// Depends on pdr_pkg.
module pdr_stack #(
  parameter int STACK_DEPTH = pdr_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  input  pdr_pkg::sym_t                  wr_data,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  output pdr_pkg::sym_t                  rd_data
);
  import pdr_pkg::*;

  sym_t mem [STACK_DEPTH];
  sym_t mem_q_r;
  sym_t byp_data_r;
  logic byp_r;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r    <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  // A read of the address written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : mem_q_r;

endmodule

// ===== rtl/core/pushdown_recognizer.sv =====
// Top level of the table-driven pushdown recognizer: configuration
// registers, input register, transition logic and result register.
// Depends on pdr_pkg and pdr_stack.
//
// Usage:
//   Symbols of a string arrive one per beat on the in_ channel (in_symbol,
//   in_has_symbol, in_last). A beat with in_has_symbol low carries no
//   symbol and makes no transition. The beat with in_last high closes the
//   string and yields one result beat on the out_ channel (out_accepted,
//   out_status); other beats yield nothing.
//   A beat is held in the input register and processed from there into the
//   state and result registers. Throughput is one beat per cycle while no
//   string end waits on a held result: the top of stack is held in a
//   register and the stack body memory reads ahead the entry below the new
//   top, so pushes and pops can follow back to back.
//   When out_stall is high the result stays in the result register; the
//   block keeps taking beats that do not end a string, and a string end
//   waits in the input register until the result register frees up.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is written while idle;
//   start_word is sampled at the first beat of each string.
//   Reset (rst_n low, synchronous) empties both registers and leaves no
//   string open; the transition table and start word reset to zero.
module pushdown_recognizer #(
  parameter int STACK_DEPTH = pdr_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pdr_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_has_symbol,
  input  logic                          in_last,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [pdr_pkg::STATUS_W-1:0]  out_status,
  // Configuration port
  input  logic                          cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata
);
  import pdr_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  // Configuration registers
  logic [CFG_W-1:0]   table_r [TABLE_WORDS];
  logic [START_W-1:0] start_r;
  logic [TABLE_W-1:0] table_flat;

  // Input register
  logic in_v_r;
  sym_t in_sym_r;
  logic in_has_r;
  logic in_last_r;

  // Recognizer state
  logic             open_r;
  sym_t             ctrl_r;
  sym_t             top_r;
  sym_t             isym_r;
  logic [CNT_W-1:0] count_r;
  logic [STATUS_W-1:0] rej_r;

  // Result register
  logic                out_v_r;
  logic                out_acc_r;
  logic [STATUS_W-1:0] out_status_r;

  // Step logic
  sym_t                cs_w;
  sym_t                top_w;
  sym_t                isym_w;
  logic [CNT_W-1:0]    cnt_w;
  logic [STATUS_W-1:0] rej_w;
  sym_t                ctrl_nxt;
  sym_t                top_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic [STATUS_W-1:0] rej_nxt;
  logic [CNT_W-1:0]    cnt_end;
  logic [STATUS_W-1:0] status_w;
  logic [ENTRY_W-1:0]  entry_w;
  logic [5:0]          entry_idx;
  logic                push_w;
  logic                in_adv;
  logic                in_take;
  sym_t                below_w;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_WORDS; i++) begin
        table_r[i] <= '0;
      end
      start_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index <= CFG_TABLE_LAST) begin
        table_r[cfg_index] <= cfg_wdata;
      end else if (cfg_index == CFG_START) begin
        start_r <= cfg_wdata[START_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_WORDS; i++) begin
      table_flat[i*CFG_W +: CFG_W] = table_r[i];
    end
  end

  // Handshake: an item ending a string waits while the result is held.
  assign in_adv   = in_v_r && (!in_last_r || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !in_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (in_adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sym_r  <= in_symbol;
      in_has_r  <= in_has_symbol;
      in_last_r <= in_last;
    end
  end

  // A new string starts from the values in the start word.
  always_comb begin
    if (open_r) begin
      cs_w   = ctrl_r;
      top_w  = top_r;
      isym_w = isym_r;
      cnt_w  = count_r;
      rej_w  = rej_r;
    end else begin
      cs_w   = start_r[1:0];
      top_w  = start_r[3:2];
      isym_w = start_r[3:2];
      cnt_w  = CNT_ONE;
      rej_w  = ST_OK;
    end
  end

  assign entry_idx = {cs_w, in_sym_r, top_w};
  assign entry_w   = table_flat[entry_idx * ENTRY_W +: ENTRY_W];

  // One transition: table lookup, then push or pop, or a rejection code.
  always_comb begin
    ctrl_nxt = cs_w;
    top_nxt  = top_w;
    count_nxt = cnt_w;
    rej_nxt  = rej_w;
    push_w   = 1'b0;
    if (in_has_r && rej_w == ST_OK) begin
      if (cnt_w == '0) begin
        rej_nxt = ST_EMPTY;
      end else if ({1'b0, in_sym_r} >= 3'(NUM_SYMBOLS)) begin
        rej_nxt = ST_NO_TRANS;
      end else if (!entry_w[0]) begin
        rej_nxt = ST_NO_TRANS;
      end else if (entry_w[3]) begin
        if (cnt_w >= CNT_FULL) begin
          rej_nxt = ST_OVERFLOW;
        end else begin
          push_w    = 1'b1;
          top_nxt   = entry_w[5:4];
          count_nxt = cnt_w + CNT_ONE;
          ctrl_nxt  = entry_w[2:1];
        end
      end else begin
        top_nxt   = below_w;
        count_nxt = cnt_w - CNT_ONE;
        ctrl_nxt  = entry_w[2:1];
      end
    end
  end

  // End of string: drop an initial symbol on top, then check acceptance.
  always_comb begin
    cnt_end = (top_nxt == isym_w) ? count_nxt - CNT_ONE : count_nxt;
    if (rej_nxt != ST_OK) begin
      status_w = rej_nxt;
    end else if (count_nxt == '0) begin
      status_w = ST_EMPTY;
    end else if (start_r[4 + ctrl_nxt] && cnt_end == '0) begin
      status_w = ST_OK;
    end else begin
      status_w = ST_NOT_FINAL;
    end
  end

  // Recognizer state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      ctrl_r  <= '0;
      top_r   <= '0;
      isym_r  <= '0;
      count_r <= '0;
      rej_r   <= ST_OK;
    end else if (in_adv) begin
      open_r  <= !in_last_r;
      ctrl_r  <= ctrl_nxt;
      top_r   <= top_nxt;
      isym_r  <= isym_w;
      count_r <= count_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // Stack body below the top register; read ahead for the next top.
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] wr_cnt;
  assign rd_cnt = (in_adv ? count_nxt : count_r) - CNT_TWO;
  assign wr_cnt = cnt_w - CNT_ONE;

  pdr_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_adv && push_w),
    .wr_addr (wr_cnt[ADDR_W-1:0]),
    .wr_data (top_w),
    .rd_addr (rd_cnt[ADDR_W-1:0]),
    .rd_data (below_w)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (in_adv && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_last_r) begin
      out_acc_r    <= (status_w == ST_OK);
      out_status_r <= status_w;
    end
  end

  assign out_valid    = out_v_r;
  assign out_accepted = out_acc_r;
  assign out_status   = out_status_r;

endmodule

// ===== bench/pdr_checker.sv =====
// Checker for the pushdown recognizer: watches the input, result and configuration ports,
// predicts each string's verdict and compares it with the result beats. Depends on pdr_pkg.
`timescale 1ns / 100ps

module pdr_checker #(
  parameter int STACK_DEPTH = pdr_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pdr_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_has_symbol,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_accepted,
  input  logic [pdr_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            pending,
  output int                            fail_count
);
  import pdr_pkg::*;

  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
  } verdict_t;

  // Shadow copy of the configuration registers.
  logic [TABLE_W-1:0] trans_bits;
  logic [START_W-1:0] start_reg;

  // Shadow copy of the recognizer state.
  logic [1:0]          ctl_state;
  logic [1:0]          base_sym;
  logic [1:0]          stk [STACK_DEPTH];
  int                  depth;
  logic [STATUS_W-1:0] rej;
  logic                str_open;

  verdict_t verdict_q[$];
  verdict_t got;
  verdict_t want;
  int       errs = 0;

  // Advance the shadow state by one accepted input beat.
  task automatic step_recognizer(input logic [1:0] sym, input logic has, input logic last);
    logic [ENTRY_W-1:0]  ent;
    logic [STATUS_W-1:0] code;
    verdict_t            v;
    int                  idx;
    // A new string starts from the start word as it is at its first beat.
    if (!str_open) begin
      ctl_state = start_reg[1:0];
      base_sym  = start_reg[3:2];
      stk[0]    = start_reg[3:2];
      depth     = 1;
      rej       = ST_OK;
      str_open  = 1'b1;
    end
    // All four codes are in the alphabet, so only a missing table entry gives no transition.
    if (has && rej == ST_OK) begin
      if (depth == 0) begin
        rej = ST_EMPTY;
      end else begin
        idx = int'({ctl_state, sym, stk[depth-1]});
        ent = trans_bits[idx*ENTRY_W +: ENTRY_W];
        if (!ent[0]) begin
          rej = ST_NO_TRANS;
        end else if (ent[3]) begin
          if (depth >= STACK_DEPTH) begin
            rej = ST_OVERFLOW;
          end else begin
            stk[depth] = ent[5:4];
            depth++;
            ctl_state = ent[2:1];
          end
        end else begin
          depth--;
          ctl_state = ent[2:1];
        end
      end
    end
    // The end of a string pops an initial symbol on top, then decides.
    if (last) begin
      if (rej != ST_OK) begin
        code = rej;
      end else if (depth == 0) begin
        code = ST_EMPTY;
      end else begin
        if (stk[depth-1] == base_sym) depth--;
        if (start_reg[4 + int'(ctl_state)] && depth == 0) code = ST_OK;
        else code = ST_NOT_FINAL;
      end
      v.accepted = (code == ST_OK);
      v.status   = code;
      verdict_q.push_back(v);
      str_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trans_bits = '0;
      start_reg  = '0;
      ctl_state  = '0;
      base_sym   = '0;
      depth      = 0;
      rej        = ST_OK;
      str_open   = 1'b0;
      verdict_q.delete();
    end else begin
      // Results are compared before this edge's input beat is predicted.
      if (out_valid && !out_stall) begin
        got.accepted = out_accepted;
        got.status   = out_status;
        if (verdict_q.size() == 0) begin
          $error("result beat with no string pending: accepted %0d status %0d",
                 got.accepted, got.status);
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index <= CFG_TABLE_LAST) trans_bits[int'(cfg_index)*CFG_W +: CFG_W] = cfg_wdata;
        else if (cfg_index == CFG_START) start_reg = cfg_wdata[START_W-1:0];
      end
      if (in_valid && !in_stall) step_recognizer(in_symbol, in_has_symbol, in_last);
    end
    pending    <= verdict_q.size();
    fail_count <= errs;
  end

endmodule

// ===== bench/tb_pushdown_recognizer.sv =====
// Testbench top for the pushdown recognizer: clock, reset, configuration phases and string
// stimulus under varying back-pressure. Depends on pdr_pkg, pushdown_recognizer and pdr_checker.
`timescale 1ns / 100ps

module tb_pushdown_recognizer;
  import pdr_pkg::*;

  typedef enum int {SET_BRACKETS, SET_ZERO, SET_ONES, SET_ANBN, SET_RANDOM} setting_t;
  typedef enum int {MODE_STEADY, MODE_SENDER_GAPS, MODE_RECEIVER_STALLS, MODE_BOTH} pace_t;

  // Symbol codes of the bracket language.
  localparam sym_t SYM_OPEN  = 2'd0;
  localparam sym_t SYM_CLOSE = 2'd1;
  localparam sym_t SYM_DROP  = 2'd2;
  localparam sym_t SYM_STRAY = 2'd3;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  sym_t                 in_symbol     = '0;
  logic                 in_has_symbol = 1'b0;
  logic                 in_last       = 1'b0;
  logic                 out_stall     = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_wdata     = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_accepted;
  logic [STATUS_W-1:0]  out_status;
  int                   pending;
  int                   fail_count;

  int                 idle_pct   = 0;
  int                 stall_pct  = 0;
  int                 beats_sent = 0;
  sym_t               word_q[$];
  logic [TABLE_W-1:0] rules;
  logic [START_W-1:0] start_val;

  pushdown_recognizer uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_symbol, .in_has_symbol, .in_last,
    .out_valid, .out_stall, .out_accepted, .out_status,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  pdr_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_symbol, .in_has_symbol, .in_last,
    .out_valid, .out_stall, .out_accepted, .out_status,
    .cfg_we, .cfg_index, .cfg_wdata,
    .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [TABLE_W-1:0] with_entry(input logic [TABLE_W-1:0] tb, input int st,
                                                    input int sy, input int top,
                                                    input logic [ENTRY_W-1:0] ent);
    tb[(st*16 + sy*4 + top)*ENTRY_W +: ENTRY_W] = ent;
    return tb;
  endfunction

  function automatic logic [ENTRY_W-1:0] push_to(input logic [1:0] nxt, input logic [1:0] ps);
    return {ps, 1'b1, nxt, 1'b1};
  endfunction

  function automatic logic [ENTRY_W-1:0] pop_to(input logic [1:0] nxt);
    return {2'b00, 1'b0, nxt, 1'b1};
  endfunction

  task automatic set_pace(input pace_t p);
    case (p)
      MODE_STEADY:          begin idle_pct = 0;  stall_pct = 0;  end
      MODE_SENDER_GAPS:     begin idle_pct = 48; stall_pct = 0;  end
      MODE_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct = 48; end
      default:              begin idle_pct = 24; stall_pct = 24; end
    endcase
  endtask

  // Present one beat, after an optional gap, and hold it until it is taken.
  task automatic send_beat(input sym_t sym, input logic has, input logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_symbol     <= sym;
    in_has_symbol <= has;
    in_last       <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait until every verdict has come back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_setting(input setting_t s);
    logic [ENTRY_W-1:0] ent;
    int i;
    rules = '0;
    case (s)
      SET_BRACKETS: begin
        // Opening pushes a marker, closing pops one, a drop on the bottom empties the stack.
        for (i = 0; i < 4; i++) rules = with_entry(rules, 2, SYM_OPEN, i, push_to(2'd2, 2'd1));
        rules     = with_entry(rules, 2, SYM_CLOSE, 1, pop_to(2'd2));
        rules     = with_entry(rules, 2, SYM_DROP, 2, pop_to(2'd3));
        start_val = 8'h4A;
      end
      SET_ZERO: start_val = 8'h00;
      SET_ONES: begin
        rules     = '1;
        start_val = 8'hFF;
      end
      SET_ANBN: begin
        // a^n b^n: symbol 0 pushes in state 0, symbol 1 pops into state 1.
        rules     = with_entry(rules, 0, 0, 0, push_to(2'd0, 2'd1));
        rules     = with_entry(rules, 0, 0, 1, push_to(2'd0, 2'd1));
        rules     = with_entry(rules, 0, 1, 1, pop_to(2'd1));
        rules     = with_entry(rules, 1, 1, 1, pop_to(2'd1));
        start_val = 8'h30;
      end
      default: begin
        for (i = 0; i < 64; i++) begin
          ent    = 6'($urandom_range(63));
          ent[0] = ($urandom_range(99) < 88);
          rules[i*ENTRY_W +: ENTRY_W] = ent;
        end
        start_val = 8'($urandom_range(255));
      end
    endcase
  endtask

  // Write all table words and the start word, one register per cycle.
  task automatic load_setting();
    int i;
    for (i = 0; i <= int'(CFG_START); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= (i == int'(CFG_START)) ? {{(CFG_W-START_W){1'b0}}, start_val}
                                          : rules[i*CFG_W +: CFG_W];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(input int len);
    repeat (len) word_q.push_back(sym_t'($urandom_range(3)));
  endtask

  // Make one string shaped for the language that is loaded.
  task automatic fill_word(input setting_t s);
    int n, m, opens, closes;
    word_q.delete();
    case (s)
      SET_BRACKETS: begin
        if ($urandom_range(5) == 0) begin
          // Deep nesting around the stack limit.
          n = 61 + $urandom_range(4);
          repeat (n) word_q.push_back(SYM_OPEN);
          repeat (n) word_q.push_back(SYM_CLOSE);
        end else if ($urandom_range(9) < 7) begin
          n      = $urandom_range(6);
          opens  = n;
          closes = n;
          while (opens + closes > 0) begin
            if (opens > 0 && (closes == opens || $urandom_range(1) == 1)) begin
              word_q.push_back(SYM_OPEN);
              opens--;
            end else begin
              word_q.push_back(SYM_CLOSE);
              closes--;
            end
          end
        end else begin
          push_random($urandom_range(8));
        end
      end
      SET_ANBN: begin
        n = $urandom_range(8);
        m = ($urandom_range(3) == 0) ? $urandom_range(8) : n;
        repeat (n) word_q.push_back(2'd0);
        repeat (m) word_q.push_back(2'd1);
        if ($urandom_range(7) == 0) push_random(1);
      end
      SET_ONES: push_random(($urandom_range(5) == 0) ? 61 + $urandom_range(5) : $urandom_range(5));
      SET_ZERO: push_random($urandom_range(2));
      default:  push_random($urandom_range(10));
    endcase
  endtask

  // Send the queued string, with empty beats sprinkled in and sometimes a separate end beat.
  task automatic send_word();
    logic split_end;
    int   i;
    split_end = (word_q.size() == 0) || ($urandom_range(9) < 3);
    for (i = 0; i < word_q.size(); i++) begin
      if ($urandom_range(9) == 0) send_beat(sym_t'($urandom_range(3)), 1'b0, 1'b0);
      send_beat(word_q[i], 1'b1, !split_end && i == word_q.size() - 1);
    end
    if (split_end) send_beat(sym_t'($urandom_range(3)), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input setting_t s, input pace_t p, input int budget);
    int stop_at;
    build_setting(s);
    load_setting();
    set_pace(p);
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      fill_word(s);
      send_word();
    end
    wait_idle();
  endtask

  setting_t plan [12] = '{SET_BRACKETS, SET_ZERO, SET_ONES, SET_ANBN, SET_RANDOM, SET_RANDOM,
                          SET_BRACKETS, SET_ONES, SET_RANDOM, SET_ANBN, SET_RANDOM, SET_RANDOM};

  initial begin
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings on the bracket language, no back-pressure.
    build_setting(SET_BRACKETS);
    load_setting();
    set_pace(MODE_STEADY);
    send_beat(SYM_OPEN, 1'b0, 1'b1);                    // empty string
    send_beat(SYM_OPEN, 1'b1, 1'b0);
    send_beat(SYM_CLOSE, 1'b1, 1'b1);                   // balanced pair
    send_beat(SYM_CLOSE, 1'b1, 1'b1);                   // no transition
    send_beat(SYM_OPEN, 1'b1, 1'b1);                    // left open
    send_beat(SYM_DROP, 1'b1, 1'b0);
    send_beat(SYM_OPEN, 1'b1, 1'b1);                    // symbol on an empty stack
    send_beat(SYM_DROP, 1'b1, 1'b1);                    // empty stack at the end
    send_beat(SYM_STRAY, 1'b1, 1'b1);                   // symbol with no entry
    send_beat(SYM_CLOSE, 1'b1, 1'b0);
    send_beat(SYM_OPEN, 1'b1, 1'b0);
    send_beat(SYM_CLOSE, 1'b1, 1'b1);                   // first rejection is kept
    send_beat(SYM_OPEN, 1'b1, 1'b0);
    send_beat(SYM_STRAY, 1'b0, 1'b0);
    send_beat(SYM_CLOSE, 1'b1, 1'b0);
    send_beat(SYM_STRAY, 1'b0, 1'b1);                   // empty beats inside a string
    send_beat(SYM_OPEN, 1'b1, 1'b0);
    send_beat(SYM_OPEN, 1'b1, 1'b0);
    send_beat(SYM_CLOSE, 1'b1, 1'b0);
    send_beat(SYM_CLOSE, 1'b1, 1'b1);
    wait_idle();

    // A new start word between strings: start in state 3, which has no moves.
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= {{(CFG_W-START_W){1'b0}}, 8'h4B};
    @(posedge clk);
    cfg_we <= 1'b0;
    send_beat(SYM_OPEN, 1'b1, 1'b1);
    send_beat(SYM_OPEN, 1'b0, 1'b1);
    wait_idle();

    // Random phases over all settings and pacing modes.
    for (p = 0; p < 12; p++) run_phase(plan[p], pace_t'(p % 4), (plan[p] == SET_ZERO) ? 50 : 90);

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pushdown_recognizer test passed");
    end else begin
      $display("pushdown_recognizer test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("pushdown_recognizer test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pdr_pkg.sv
rtl/core/pdr_stack.sv
rtl/core/pushdown_recognizer.sv
bench/pdr_checker.sv
bench/tb_pushdown_recognizer.sv
